### design/tcpr_pkg.sv
// shared constants for the tiered capacity put router
package tcpr_pkg;

   localparam int MAX_NODES_DEF = 16;
   localparam int MAX_KEYS_DEF  = 64;
   localparam int NTIERS        = 3;
   localparam int NONE_NODE     = 16;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_KEY  = 1'b1;

   localparam logic [1:0] TIER_HBM  = 2'd0;
   localparam logic [1:0] TIER_DRAM = 2'd1;
   localparam logic [1:0] TIER_SSD  = 2'd2;

   localparam logic [1:0] OUT_ROUTED     = 2'd0;
   localparam logic [1:0] OUT_EXISTS     = 2'd1;
   localparam logic [1:0] OUT_UNROUTABLE = 2'd2;

   localparam logic [1:0] AFF_REQUESTER = 2'd1;
   localparam logic [1:0] AFF_TOGETHER  = 2'd2;

   localparam logic [1:0] SSD_ALWAYS = 2'd1;
   localparam logic [1:0] SSD_NEVER  = 2'd2;

   localparam logic SEL_ROUND_ROBIN = 1'b1;

   localparam logic [2:0] REG_SELECT    = 3'd0;
   localparam logic [2:0] REG_AFFINITY  = 3'd1;
   localparam logic [2:0] REG_SSD       = 3'd2;
   localparam logic [2:0] REG_REQUESTER = 3'd3;
   localparam logic [2:0] REG_EXCLUDE   = 3'd4;

endpackage

### design/tcpr_ram.sv
// generic simple dual port ram with registered read
module tcpr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 48
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### design/tiered_capacity_put_router.sv
// Placement takes one transaction at a time and holds busy high from the last key until every
// result has gone out. A load or a non-final key is taken without raising busy. Placement runs
// over the free table memory, reading and checking one node at a time in each tier scan; up to
// three tiers are tried per pass, round robin adds a remainder step and a second scan, and
// the key is fetched before placement; the return, deduction and result follow it.
// Keep-together first sums the non-duplicate key sizes of the batch. Results come as
// single-cycle rsp_valid strobes that the receiver must take as they come.
module tiered_capacity_put_router #(
   parameter int MAX_NODES = tcpr_pkg::MAX_NODES_DEF,
   parameter int MAX_KEYS  = tcpr_pkg::MAX_KEYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [3:0]  req_node_index,
   input  logic [1:0]  req_tier_sel,
   input  logic [63:0] req_avail_bytes,
   input  logic [63:0] req_capacity_bytes,
   input  logic [63:0] req_block_bytes,
   input  logic        req_dedup_hit,
   input  logic        req_last_key,
   output logic        rsp_valid,
   output logic [1:0]  rsp_outcome,
   output logic [3:0]  rsp_chosen_node,
   output logic [1:0]  rsp_chosen_tier,
   output logic [5:0]  rsp_key_position,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import tcpr_pkg::*;

   localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int SLOTS  = MAX_NODES * NTIERS;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int KI_W   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int KC_W   = $clog2(MAX_KEYS + 1);

   localparam logic [4:0] ST_IDLE = 5'd0, ST_BATCH = 5'd1, ST_SUM_NEXT = 5'd2,
      ST_SUM_RD = 5'd3, ST_SUM_EV = 5'd4, ST_KEY_NEXT = 5'd5, ST_KEY_RD = 5'd6,
      ST_KEY_EV = 5'd7, ST_P_TIER = 5'd8, ST_P_PEV = 5'd9, ST_S_RD = 5'd10,
      ST_S_EV = 5'd11, ST_S_END = 5'd12, ST_DIV = 5'd13, ST_RET = 5'd14,
      ST_DED_RD = 5'd15, ST_DED_WR = 5'd16, ST_EMIT = 5'd17, ST_FINISH = 5'd18;

   localparam logic [2:0] CALL_SUM = 3'd0, CALL_A1_NODE = 3'd1, CALL_A1_MODE = 3'd2,
      CALL_PIN = 3'd3, CALL_A2_MODE = 3'd4, CALL_PLAIN = 3'd5;

   logic [4:0]        state_ff, state_in;
   logic              sel_ff, sel_in;
   logic [1:0]        aff_ff, aff_in;
   logic [1:0]        ssd_ff, ssd_in;
   logic [4:0]        reqn_ff, reqn_in;
   logic [15:0]       excl_ff, excl_in;
   logic [SLOTS-1:0]  present_ff, present_in;
   logic [MAX_NODES-1:0] host_ff, host_in;
   logic [KC_W-1:0]   kcount_ff, kcount_in;
   logic [KC_W-1:0]   ki_ff, ki_in;
   logic [63:0]       cursor_ff, cursor_in;
   logic              anc_v_ff, anc_v_in, pin_v_ff, pin_v_in;
   logic [NODE_W-1:0] anc_ff, anc_in;
   logic [1:0]        pin_ff, pin_in;
   logic [63:0]       total_ff, total_in;
   logic [63:0]       cur_size_ff, cur_size_in;
   logic [2:0]        call_ff, call_in;
   logic [63:0]       psize_ff, psize_in;
   logic              pref_ff, pref_in, onnode_ff, onnode_in;
   logic [NODE_W-1:0] prefn_ff, prefn_in;
   logic [1:0]        t_ff, t_in, thi_ff, thi_in;
   logic [CNT_W-1:0]  n_ff, n_in, cnt_ff, cnt_in, k_ff, k_in, rem_ff, rem_in;
   logic [NODE_W-1:0] bestn_ff, bestn_in;
   logic [63:0]       best_ff, best_in;
   logic              rr2_ff, rr2_in, ok_ff, ok_in;
   logic [NODE_W-1:0] resn_ff, resn_in;
   logic [1:0]        rest_ff, rest_in;
   logic [63:0]       divq_ff, divq_in;
   logic [5:0]        divc_ff, divc_in;
   logic [1:0]        ocode_ff, ocode_in;
   logic              rv_ff, rv_in;
   logic [1:0]        ro_ff, ro_in, rt_ff, rt_in;
   logic [3:0]        rn_ff, rn_in;
   logic [5:0]        rp_ff, rp_in;
   logic              rl_ff, rl_in;

   logic              fwe;
   logic [SLOT_W-1:0] fwaddr, fraddr;
   logic [63:0]       fwdata, frdata;
   logic              kwe;
   logic [KI_W-1:0]   kraddr;
   logic [64:0]       krdata;

   logic              accept;
   logic [1:0]        tier_hi;
   logic [NODE_W-1:0] ev_node;
   logic              fits_now;
   logic [6:0]        ev_nx;
   logic [SLOT_W-1:0] ev_slot;
   logic [CNT_W:0]    rem_sh;
   logic              req_ok;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [NODE_W-1:0] node,
                                                 input logic [1:0] tier);
      int s;
      s = int'(node) * NTIERS + int'(tier);
      return SLOT_W'(s);
   endfunction

   tcpr_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_free (
      .clock(clock), .wr_en(fwe), .wr_addr(fwaddr), .wr_data(fwdata),
      .rd_addr(fraddr), .rd_data(frdata)
   );

   tcpr_ram #(.WIDTH(65), .DEPTH(MAX_KEYS)) u_keys (
      .clock(clock), .wr_en(kwe), .wr_addr(kcount_ff[KI_W-1:0]),
      .wr_data({req_dedup_hit, req_block_bytes}), .rd_addr(kraddr), .rd_data(krdata)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign tier_hi   = (ssd_ff == SSD_NEVER) ? TIER_DRAM : TIER_SSD;
   assign req_ok    = (int'(reqn_ff) != NONE_NODE) && (int'(reqn_ff) < MAX_NODES);
   assign ev_node   = (state_ff == ST_P_TIER || state_ff == ST_P_PEV) ? prefn_ff
                                                                     : n_ff[NODE_W-1:0];
   assign ev_nx     = 7'(ev_node);
   assign ev_slot   = slot_of(ev_node, t_ff);
   assign rem_sh    = {rem_ff, divq_ff[63]};

   always_comb begin
      fits_now = present_ff[ev_slot] && (frdata >= psize_ff);
      if ((ev_nx < 7'd16) && excl_ff[ev_nx[3:0]]) begin
         fits_now = 1'b0;
      end
      if (t_ff == TIER_SSD) begin
         if (ssd_ff == SSD_NEVER) begin
            fits_now = 1'b0;
         end else if (ssd_ff != SSD_ALWAYS && host_ff[ev_node]) begin
            fits_now = 1'b0;
         end
      end
   end

   always_comb begin
      fraddr = ev_slot;
      if (state_ff == ST_DED_RD) begin
         fraddr = slot_of(resn_ff, rest_ff);
      end
      kraddr = ki_ff[KI_W-1:0];
   end

   always_comb begin
      state_in = state_ff; sel_in = sel_ff; aff_in = aff_ff; ssd_in = ssd_ff;
      reqn_in = reqn_ff; excl_in = excl_ff; present_in = present_ff; host_in = host_ff;
      kcount_in = kcount_ff; ki_in = ki_ff; cursor_in = cursor_ff;
      anc_v_in = anc_v_ff; pin_v_in = pin_v_ff; anc_in = anc_ff; pin_in = pin_ff;
      total_in = total_ff; cur_size_in = cur_size_ff;
      call_in = call_ff; psize_in = psize_ff; pref_in = pref_ff; onnode_in = onnode_ff;
      prefn_in = prefn_ff; t_in = t_ff; thi_in = thi_ff; n_in = n_ff; cnt_in = cnt_ff;
      k_in = k_ff; rem_in = rem_ff; bestn_in = bestn_ff; best_in = best_ff;
      rr2_in = rr2_ff; ok_in = ok_ff; resn_in = resn_ff; rest_in = rest_ff;
      divq_in = divq_ff; divc_in = divc_ff; ocode_in = ocode_ff;
      rv_in = 1'b0; ro_in = ro_ff; rn_in = rn_ff; rt_in = rt_ff; rp_in = rp_ff; rl_in = rl_ff;
      fwe = 1'b0; fwaddr = slot_of(resn_ff, rest_ff); fwdata = frdata - cur_size_ff;
      kwe = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            REG_SELECT:    sel_in = csr_data[0];
            REG_AFFINITY:  aff_in = csr_data[1:0];
            REG_SSD:       ssd_in = csr_data[1:0];
            REG_REQUESTER: reqn_in = csr_data[4:0];
            REG_EXCLUDE:   excl_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_LOAD) begin
                  if ((int'(req_node_index) < MAX_NODES) && (req_tier_sel != 2'd3)) begin
                     fwe = 1'b1;
                     fwaddr = slot_of(NODE_W'(req_node_index), req_tier_sel);
                     fwdata = req_avail_bytes;
                     present_in[fwaddr] = 1'b1;
                     if (req_tier_sel != TIER_SSD && req_capacity_bytes != 64'd0) begin
                        host_in[NODE_W'(req_node_index)] = 1'b1;
                     end
                  end
               end else begin
                  if (int'(kcount_ff) < MAX_KEYS) begin
                     kwe = 1'b1;
                     kcount_in = kcount_ff + 1'b1;
                  end
                  if (req_last_key) begin
                     state_in = ST_BATCH;
                  end
               end
            end
         end
         ST_BATCH: begin
            anc_v_in = 1'b0; pin_v_in = 1'b0; anc_in = '0; pin_in = TIER_HBM;
            ki_in = '0; total_in = '0;
            if (aff_ff == AFF_REQUESTER) begin
               anc_v_in = req_ok;
               anc_in = NODE_W'(reqn_ff);
               state_in = ST_KEY_NEXT;
            end else if (aff_ff == AFF_TOGETHER) begin
               state_in = ST_SUM_NEXT;
            end else begin
               state_in = ST_KEY_NEXT;
            end
         end
         ST_SUM_NEXT: begin
            if (ki_ff == kcount_ff) begin
               ki_in = '0;
               if (total_ff != 64'd0) begin
                  call_in = CALL_SUM; psize_in = total_ff; pref_in = 1'b0;
                  onnode_in = 1'b0; t_in = TIER_HBM; thi_in = tier_hi;
                  state_in = ST_P_TIER;
               end else begin
                  state_in = ST_KEY_NEXT;
               end
            end else begin
               state_in = ST_SUM_RD;
            end
         end
         ST_SUM_RD: state_in = ST_SUM_EV;
         ST_SUM_EV: begin
            if (!krdata[64]) begin
               total_in = total_ff + krdata[63:0];
            end
            ki_in = ki_ff + 1'b1;
            state_in = ST_SUM_NEXT;
         end
         ST_KEY_NEXT: begin
            state_in = (ki_ff == kcount_ff) ? ST_FINISH : ST_KEY_RD;
         end
         ST_KEY_RD: state_in = ST_KEY_EV;
         ST_KEY_EV: begin
            cur_size_in = krdata[63:0];
            psize_in = krdata[63:0];
            pref_in = 1'b0; onnode_in = 1'b0; t_in = TIER_HBM; thi_in = tier_hi;
            state_in = ST_P_TIER;
            if (krdata[64]) begin
               ocode_in = OUT_EXISTS;
               state_in = ST_EMIT;
            end else if (aff_ff == AFF_REQUESTER) begin
               if (anc_v_ff) begin
                  call_in = CALL_A1_NODE; pref_in = 1'b1; onnode_in = 1'b1; prefn_in = anc_ff;
               end else begin
                  call_in = CALL_A1_MODE;
               end
            end else if (aff_ff == AFF_TOGETHER) begin
               if (pin_v_ff) begin
                  call_in = CALL_PIN; pref_in = 1'b1; onnode_in = 1'b1; prefn_in = anc_ff;
                  t_in = pin_ff; thi_in = pin_ff;
               end else begin
                  call_in = CALL_A2_MODE; pref_in = anc_v_ff; prefn_in = anc_ff;
               end
            end else begin
               call_in = CALL_PLAIN;
            end
         end
         ST_P_TIER: begin
            if (t_ff > thi_ff) begin
               ok_in = 1'b0;
               state_in = ST_RET;
            end else if (pref_ff) begin
               state_in = ST_P_PEV;
            end else begin
               n_in = '0; cnt_in = '0; rr2_in = 1'b0;
               state_in = ST_S_RD;
            end
         end
         ST_P_PEV: begin
            if (fits_now) begin
               ok_in = 1'b1; resn_in = prefn_ff; rest_in = t_ff;
               state_in = ST_RET;
            end else if (onnode_ff) begin
               t_in = t_ff + 1'b1;
               state_in = ST_P_TIER;
            end else begin
               n_in = '0; cnt_in = '0; rr2_in = 1'b0;
               state_in = ST_S_RD;
            end
         end
         ST_S_RD: state_in = ST_S_EV;
         ST_S_EV: begin
            n_in = n_ff + 1'b1;
            state_in = (int'(n_ff) + 1 == MAX_NODES) ? ST_S_END : ST_S_RD;
            if (fits_now) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == '0 || frdata > best_ff) begin
                  best_in = frdata;
                  bestn_in = n_ff[NODE_W-1:0];
               end
               if (rr2_ff) begin
                  if (k_ff == '0) begin
                     ok_in = 1'b1; resn_in = n_ff[NODE_W-1:0]; rest_in = t_ff;
                     cursor_in = cursor_ff + 64'd1;
                     state_in = ST_RET;
                  end else begin
                     k_in = k_ff - 1'b1;
                  end
               end
            end
         end
         ST_S_END: begin
            if (cnt_ff == '0) begin
               t_in = t_ff + 1'b1;
               state_in = ST_P_TIER;
            end else if (sel_ff != SEL_ROUND_ROBIN) begin
               ok_in = 1'b1; resn_in = bestn_ff; rest_in = t_ff;
               state_in = ST_RET;
            end else begin
               divq_in = cursor_ff; divc_in = '0; rem_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            divq_in = {divq_ff[62:0], 1'b0};
            divc_in = divc_ff + 1'b1;
            if (rem_sh >= {1'b0, cnt_ff}) begin
               rem_in = CNT_W'(rem_sh - {1'b0, cnt_ff});
            end else begin
               rem_in = CNT_W'(rem_sh);
            end
            if (divc_ff == 6'd63) begin
               k_in = rem_in;
               n_in = '0; rr2_in = 1'b1;
               state_in = ST_S_RD;
            end
         end
         ST_RET: begin
            psize_in = cur_size_ff; pref_in = 1'b0; onnode_in = 1'b0;
            t_in = TIER_HBM; thi_in = tier_hi;
            case (call_ff)
               CALL_SUM: begin
                  if (ok_ff) begin
                     anc_v_in = 1'b1; anc_in = resn_ff; pin_v_in = 1'b1; pin_in = rest_ff;
                  end
                  state_in = ST_KEY_NEXT;
               end
               CALL_A1_NODE: begin
                  if (ok_ff) begin
                     state_in = ST_DED_RD;
                  end else begin
                     call_in = CALL_A1_MODE;
                     state_in = ST_P_TIER;
                  end
               end
               CALL_PIN: begin
                  if (ok_ff) begin
                     state_in = ST_DED_RD;
                  end else begin
                     call_in = CALL_A2_MODE; pref_in = anc_v_ff; prefn_in = anc_ff;
                     state_in = ST_P_TIER;
                  end
               end
               CALL_A2_MODE: begin
                  pin_v_in = 1'b0;
                  if (ok_ff) begin
                     anc_v_in = 1'b1; anc_in = resn_ff;
                     state_in = ST_DED_RD;
                  end else begin
                     ocode_in = OUT_UNROUTABLE;
                     state_in = ST_EMIT;
                  end
               end
               default: begin
                  if (ok_ff) begin
                     state_in = ST_DED_RD;
                  end else begin
                     ocode_in = OUT_UNROUTABLE;
                     state_in = ST_EMIT;
                  end
               end
            endcase
         end
         ST_DED_RD: state_in = ST_DED_WR;
         ST_DED_WR: begin
            fwe = 1'b1;
            ocode_in = OUT_ROUTED;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rv_in = 1'b1;
            ro_in = ocode_ff;
            rn_in = (ocode_ff == OUT_ROUTED) ? 4'(resn_ff) : 4'd0;
            rt_in = (ocode_ff == OUT_ROUTED) ? rest_ff : TIER_HBM;
            rp_in = 6'(ki_ff);
            rl_in = (ki_ff + 1'b1 == kcount_ff);
            ki_in = ki_ff + 1'b1;
            state_in = ST_KEY_NEXT;
         end
         ST_FINISH: begin
            kcount_in = '0; present_in = '0; host_in = '0;
            anc_v_in = 1'b0; pin_v_in = 1'b0; anc_in = '0; pin_in = TIER_HBM;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; sel_ff <= 1'b0; aff_ff <= 2'd0; ssd_ff <= 2'd0;
         reqn_ff <= 5'(NONE_NODE); excl_ff <= '0; present_ff <= '0; host_ff <= '0;
         kcount_ff <= '0; cursor_ff <= '0; anc_v_ff <= 1'b0; pin_v_ff <= 1'b0;
         anc_ff <= '0; pin_ff <= TIER_HBM; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; sel_ff <= sel_in; aff_ff <= aff_in; ssd_ff <= ssd_in;
         reqn_ff <= reqn_in; excl_ff <= excl_in; present_ff <= present_in;
         host_ff <= host_in; kcount_ff <= kcount_in; cursor_ff <= cursor_in;
         anc_v_ff <= anc_v_in; pin_v_ff <= pin_v_in; anc_ff <= anc_in; pin_ff <= pin_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      ki_ff <= ki_in; total_ff <= total_in; cur_size_ff <= cur_size_in;
      call_ff <= call_in; psize_ff <= psize_in;
      pref_ff <= pref_in; onnode_ff <= onnode_in; prefn_ff <= prefn_in;
      t_ff <= t_in; thi_ff <= thi_in; n_ff <= n_in; cnt_ff <= cnt_in; k_ff <= k_in;
      rem_ff <= rem_in; bestn_ff <= bestn_in; best_ff <= best_in; rr2_ff <= rr2_in;
      ok_ff <= ok_in; resn_ff <= resn_in; rest_ff <= rest_in; divq_ff <= divq_in;
      divc_ff <= divc_in; ocode_ff <= ocode_in; ro_ff <= ro_in; rn_ff <= rn_in;
      rt_ff <= rt_in; rp_ff <= rp_in; rl_ff <= rl_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_outcome      = ro_ff;
   assign rsp_chosen_node  = rn_ff;
   assign rsp_chosen_tier  = rt_ff;
   assign rsp_key_position = rp_ff;
   assign rsp_last_result  = rl_ff;
endmodule

### design/tcpr_checker.sv
// port level checks for the tiered capacity put router
module tcpr_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_op,
   input logic       rsp_valid,
   input logic [1:0] rsp_outcome,
   input logic [3:0] rsp_chosen_node,
   input logic [1:0] rsp_chosen_tier
);
   import tcpr_pkg::*;

   // results only while a batch is being placed
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a batch");

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back results");

   a_unrouted_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome != OUT_ROUTED) |->
      (rsp_chosen_node == 4'd0 && rsp_chosen_tier == TIER_HBM))
      else $error("placement on an unrouted result");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_LOAD) |=> !busy)
      else $error("load transaction started a batch");
endmodule

bind tiered_capacity_put_router tcpr_checker u_tcpr_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_op(req_op),
   .rsp_valid(rsp_valid), .rsp_outcome(rsp_outcome),
   .rsp_chosen_node(rsp_chosen_node), .rsp_chosen_tier(rsp_chosen_tier)
);

### test/tcpr_checker.sv
// checker for the put router: predicts placement results and compares them with the block
module tcpr_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_op,
   input  logic [3:0]  req_node_index,
   input  logic [1:0]  req_tier_sel,
   input  logic [63:0] req_avail_bytes,
   input  logic [63:0] req_capacity_bytes,
   input  logic [63:0] req_block_bytes,
   input  logic        req_dedup_hit,
   input  logic        req_last_key,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_outcome,
   input  logic [3:0]  rsp_chosen_node,
   input  logic [1:0]  rsp_chosen_tier,
   input  logic [5:0]  rsp_key_position,
   input  logic        rsp_last_result,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          errors,
   output int          pending
);
   import tcpr_pkg::*;

   typedef struct packed {
      logic [1:0] outcome;
      logic [3:0] node;
      logic [1:0] tier;
      logic [5:0] pos;
      logic       last;
   } placement_type;

   placement_type placements[$];

   logic        sel_mode;
   logic [1:0]  aff_mode;
   logic [1:0]  ssd_pol;
   logic [4:0]  req_node;
   logic [15:0] excl;

   logic [63:0] free_mem[48];
   bit          present[48];
   bit          host_mem[16];
   logic [63:0] key_size[64];
   bit          key_dup[64];
   int          key_cnt;
   logic [63:0] cursor;

   assign pending = placements.size();

   function automatic bit fits(int n, int t, logic [63:0] sz);
      int s;
      if (n >= 16 || t >= 3) return 0;
      if (excl[n]) return 0;
      if (t == 2) begin
         if (ssd_pol == SSD_NEVER) return 0;
         if (ssd_pol != SSD_ALWAYS && host_mem[n]) return 0;
      end
      s = n * 3 + t;
      if (!present[s]) return 0;
      return free_mem[s] >= sz;
   endfunction

   function automatic bit pick_on_node(int n, logic [63:0] sz, output int t_o);
      int lim;
      lim = (ssd_pol == SSD_NEVER) ? 2 : 3;
      t_o = 0;
      for (int t = 0; t < lim; t++)
         if (fits(n, t, sz)) begin
            t_o = t;
            return 1;
         end
      return 0;
   endfunction

   function automatic bit pick_by_mode(logic [63:0] sz, bit pref, int pnode,
                                       output int n_o, output int t_o);
      int lim, cnt, best;
      int lst[16];
      lim = (ssd_pol == SSD_NEVER) ? 2 : 3;
      n_o = 0;
      t_o = 0;
      for (int t = 0; t < lim; t++) begin
         if (pref && fits(pnode, t, sz)) begin
            n_o = pnode;
            t_o = t;
            return 1;
         end
         cnt = 0;
         for (int n = 0; n < 16; n++)
            if (fits(n, t, sz)) begin
               lst[cnt] = n;
               cnt = cnt + 1;
            end
         if (cnt == 0) continue;
         if (sel_mode == SEL_ROUND_ROBIN) begin
            best = lst[int'(cursor % 64'(cnt))];
            cursor = cursor + 1;
         end else begin
            best = lst[0];
            for (int i = 1; i < cnt; i++)
               if (free_mem[lst[i] * 3 + t] > free_mem[best * 3 + t]) best = lst[i];
         end
         n_o = best;
         t_o = t;
         return 1;
      end
      return 0;
   endfunction

   task automatic place_batch();
      bit            anc_v, pin_v, ok;
      int            anc_n, pin_t, n, t;
      logic [63:0]   total;
      placement_type p;
      anc_v = 0;
      pin_v = 0;
      anc_n = 0;
      pin_t = 0;
      total = '0;
      if (aff_mode == AFF_REQUESTER) begin
         if (req_node < 16) begin
            anc_v = 1;
            anc_n = req_node;
         end
      end else if (aff_mode == AFF_TOGETHER) begin
         for (int i = 0; i < key_cnt; i++)
            if (!key_dup[i]) total = total + key_size[i];
         if (total != 0 && pick_by_mode(total, 0, 0, n, t)) begin
            anc_v = 1;
            anc_n = n;
            pin_v = 1;
            pin_t = t;
         end
      end
      for (int i = 0; i < key_cnt; i++) begin
         p = '0;
         p.pos = i[5:0];
         p.last = (i + 1 == key_cnt);
         ok = 0;
         n = 0;
         t = 0;
         if (key_dup[i]) begin
            p.outcome = OUT_EXISTS;
            placements = {placements, p};
            continue;
         end
         if (aff_mode == AFF_REQUESTER) begin
            if (anc_v && pick_on_node(anc_n, key_size[i], t)) begin
               n = anc_n;
               ok = 1;
            end
            if (!ok) ok = pick_by_mode(key_size[i], 0, 0, n, t);
         end else if (aff_mode == AFF_TOGETHER) begin
            if (pin_v && fits(anc_n, pin_t, key_size[i])) begin
               n = anc_n;
               t = pin_t;
               ok = 1;
            end
            if (!ok) begin
               ok = pick_by_mode(key_size[i], anc_v, anc_n, n, t);
               pin_v = 0;
               if (ok) begin
                  anc_v = 1;
                  anc_n = n;
               end
            end
         end else begin
            ok = pick_by_mode(key_size[i], 0, 0, n, t);
         end
         if (ok) begin
            free_mem[n * 3 + t] = free_mem[n * 3 + t] - key_size[i];
            p.outcome = OUT_ROUTED;
            p.node = n[3:0];
            p.tier = t[1:0];
         end else begin
            p.outcome = OUT_UNROUTABLE;
         end
         placements = {placements, p};
      end
      key_cnt = 0;
      for (int s = 0; s < 48; s++) present[s] = 0;
      for (int s = 0; s < 16; s++) host_mem[s] = 0;
   endtask

   always @(posedge clock) begin
      placement_type e;
      int            bad;
      bad = 0;
      if (reset) begin
         errors <= 0;
         sel_mode = 0;
         aff_mode = 0;
         ssd_pol = 0;
         req_node = 5'(NONE_NODE);
         excl = '0;
         key_cnt = 0;
         cursor = '0;
         for (int s = 0; s < 48; s++) present[s] = 0;
         for (int s = 0; s < 16; s++) host_mem[s] = 0;
         placements.delete();
      end else begin
         if (rsp_valid) begin
            if (placements.size() == 0) begin
               $error("result with no transaction pending");
               bad = bad + 1;
            end else begin
               e = placements.pop_front();
               if (rsp_outcome !== e.outcome) begin
                  $error("outcome expected %0d got %0d", e.outcome, rsp_outcome);
                  bad = bad + 1;
               end
               if (rsp_chosen_node !== e.node) begin
                  $error("chosen_node expected %0d got %0d", e.node, rsp_chosen_node);
                  bad = bad + 1;
               end
               if (rsp_chosen_tier !== e.tier) begin
                  $error("chosen_tier expected %0d got %0d", e.tier, rsp_chosen_tier);
                  bad = bad + 1;
               end
               if (rsp_key_position !== e.pos) begin
                  $error("key_position expected %0d got %0d", e.pos, rsp_key_position);
                  bad = bad + 1;
               end
               if (rsp_last_result !== e.last) begin
                  $error("last_result expected %0d got %0d", e.last, rsp_last_result);
                  bad = bad + 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SELECT:    sel_mode = csr_data[0];
               REG_AFFINITY:  aff_mode = csr_data[1:0];
               REG_SSD:       ssd_pol = csr_data[1:0];
               REG_REQUESTER: req_node = csr_data[4:0];
               REG_EXCLUDE:   excl = csr_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_op == OP_LOAD) begin
               if (req_tier_sel < 3) begin
                  free_mem[req_node_index * 3 + req_tier_sel] = req_avail_bytes;
                  present[req_node_index * 3 + req_tier_sel] = 1;
                  if (req_tier_sel < 2 && req_capacity_bytes != 0) host_mem[req_node_index] = 1;
               end
            end else begin
               if (key_cnt < 64) begin
                  key_size[key_cnt] = req_block_bytes;
                  key_dup[key_cnt] = req_dedup_hit;
                  key_cnt = key_cnt + 1;
               end
               if (req_last_key) place_batch();
            end
         end
         errors <= errors + bad;
      end
   end

endmodule

### test/tiered_capacity_put_router_tb.sv
// testbench top for the put router: stimulus, configuration phases and verdict
module tiered_capacity_put_router_tb;
   import tcpr_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_op = 0;
   logic [3:0]  req_node_index = 0;
   logic [1:0]  req_tier_sel = 0;
   logic [63:0] req_avail_bytes = 0;
   logic [63:0] req_capacity_bytes = 0;
   logic [63:0] req_block_bytes = 0;
   logic        req_dedup_hit = 0;
   logic        req_last_key = 0;
   logic        rsp_valid;
   logic [1:0]  rsp_outcome;
   logic [3:0]  rsp_chosen_node;
   logic [1:0]  rsp_chosen_tier;
   logic [5:0]  rsp_key_position;
   logic        rsp_last_result;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = 0;
   logic [15:0] csr_data = 0;
   int          errors;
   int          pending;
   int          sent;
   bit          calm;

   always #5 clock = ~clock;

   tiered_capacity_put_router uut (.*);
   tcpr_scoreboard chk (.*);

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send(logic op, logic [3:0] node, logic [1:0] tier, logic [63:0] avail,
                       logic [63:0] cap, logic [63:0] blk, logic dup, logic last);
      if (!calm && $urandom_range(99) < 22) begin
         start <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_op <= op;
      req_node_index <= node;
      req_tier_sel <= tier;
      req_avail_bytes <= avail;
      req_capacity_bytes <= cap;
      req_block_bytes <= blk;
      req_dedup_hit <= dup;
      req_last_key <= last;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   task automatic settle();
      start <= 0;
      @(posedge clock);
      while (busy || pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] data);
      if (!calm && $urandom_range(99) < 22) begin
         csr_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(logic sel, logic [1:0] aff, logic [1:0] ssd, logic [4:0] rq,
                            logic [15:0] ex);
      settle();
      write_reg(REG_SELECT, {15'd0, sel});
      write_reg(REG_AFFINITY, {14'd0, aff});
      write_reg(REG_SSD, {14'd0, ssd});
      write_reg(REG_REQUESTER, {11'd0, rq});
      write_reg(REG_EXCLUDE, ex);
      csr_valid <= 0;
   endtask

   task automatic random_batch(int nkeys, bit with_loads);
      logic [63:0] v;
      logic [63:0] c;
      if (with_loads)
         repeat ($urandom_range(3, 20)) begin
            v = ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(0, 2000));
            c = ($urandom_range(2) == 0) ? 64'd0 : rand64();
            send(OP_LOAD, 4'($urandom_range(15)),
                 ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2)), v, c, rand64(),
                 1'($urandom), 1'($urandom));
         end
      for (int k = 0; k < nkeys; k++) begin
         v = ($urandom_range(7) == 0) ? rand64() : 64'($urandom_range(0, 700));
         send(OP_KEY, 4'($urandom), 2'($urandom), rand64(), rand64(), v,
              $urandom_range(5) == 0, k == nkeys - 1);
      end
   endtask

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      sent = 0;
      calm = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // extremes of the fields, defaults first
      send(OP_LOAD, 4'd0, TIER_HBM, '1, '1, 0, 0, 0);
      send(OP_LOAD, 4'd15, TIER_DRAM, 64'd0, 64'd0, '1, 1, 1);
      send(OP_LOAD, 4'd15, TIER_SSD, 64'd1000, 64'd0, 0, 0, 0);
      send(OP_LOAD, 4'd3, 2'd3, '1, '1, 0, 0, 0);
      send(OP_LOAD, 4'd0, TIER_DRAM, 64'd0, 64'd0, 0, 0, 0);
      send(OP_KEY, 4'd0, 2'd0, 0, 0, 64'd500, 0, 0);
      send(OP_KEY, 4'd0, 2'd0, 0, 0, '1, 0, 0);
      send(OP_KEY, 4'd15, 2'd3, '1, '1, 64'd0, 1, 0);
      send(OP_KEY, 4'd0, 2'd0, 0, 0, 64'd600, 0, 1);
      configure(SEL_ROUND_ROBIN, AFF_TOGETHER, SSD_ALWAYS, 5'd15, 16'hFFFE);
      send(OP_LOAD, 4'd0, TIER_SSD, 64'd5000, 64'd0, 0, 0, 0);
      send(OP_LOAD, 4'd1, TIER_HBM, 64'd5000, 64'd9, 0, 0, 0);
      send(OP_KEY, 4'd0, 2'd0, 0, 0, 64'd100, 0, 0);
      send(OP_KEY, 4'd0, 2'd0, 0, 0, 64'd100, 1, 1);
      configure(1'b0, 2'd3, 2'd3, 5'd31, 16'hFFFF);
      send(OP_LOAD, 4'd2, TIER_DRAM, 64'd50, 64'd1, 0, 0, 0);
      send(OP_KEY, 4'd0, 2'd0, 0, 0, 64'd10, 0, 1);
      configure(1'b0, AFF_REQUESTER, SSD_NEVER, 5'd2, 16'h0000);
      random_batch(3, 1);
      // buffer overflow: more keys than the buffer holds
      configure(SEL_ROUND_ROBIN, 2'd0, 2'd0, 5'd16, 16'h0000);
      random_batch(70, 1);

      while (sent < 300) begin
         calm = ($urandom_range(9) == 0);
         configure(1'($urandom), 2'($urandom), 2'($urandom), 5'($urandom),
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'(1 << $urandom_range(15)));
         repeat ($urandom_range(1, 4))
            random_batch(($urandom_range(19) == 0) ? $urandom_range(1, 66)
                         : $urandom_range(1, 6), $urandom_range(9) != 0);
      end
      calm = 0;
      settle();
      if (errors == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### tiered_capacity_put_router.f
design/tcpr_pkg.sv
design/tcpr_ram.sv
design/tiered_capacity_put_router.sv
design/tcpr_checker.sv
test/tcpr_checker.sv
test/tiered_capacity_put_router_tb.sv
